// ===== sv/qte_pkg.sv =====
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN = 24;

    localparam int Q_W = 16;
    localparam int P_W = 32;
    localparam int CIN_W = 34;
    localparam int Z_W = 34;
    localparam int SQ_IN_W = 63;
    localparam int SQ_OUT_W = 32;

    localparam logic [29:0] ATAN_TAB [TABLE_LEN] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    localparam logic signed [Z_W-1:0] HALF_PI = Z_W'({ATAN_TAB[0], 1'b0});

    localparam logic [28:0] DEG_K = 29'd480631834;

endpackage

// ===== sv/qte_isqrt.sv =====
module qte_isqrt
    import qte_pkg::*;
(
    input  logic                clk,
    input  logic                ce,
    input  logic [SQ_IN_W-1:0]  v_in,
    output logic [SQ_OUT_W-1:0] root
);

    localparam int STEPS = SQ_OUT_W;

    logic [63:0] rem_reg [STEPS];
    logic [63:0] r_reg   [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
            logic [63:0] rem_in;
            logic [63:0] r_in;
            logic [63:0] trial;
            logic [63:0] rem_next;
            logic [63:0] r_next;

            if (k == 0) begin : g_first
                assign rem_in = 64'(v_in);
                assign r_in   = '0;
            end
            else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign r_in   = r_reg[k-1];
            end

            always_comb
            begin
                trial = r_in + BIT;
                if (rem_in >= trial)
                begin
                    rem_next = rem_in - trial;
                    r_next   = (r_in >> 1) + BIT;
                end
                else
                begin
                    rem_next = rem_in;
                    r_next   = r_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k] <= rem_next;
                    r_reg[k]   <= r_next;
                end
            end
        end
    endgenerate

    assign root = r_reg[STEPS-1][SQ_OUT_W-1:0];

endmodule

// ===== sv/qte_cordic.sv =====
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                    clk,
    input  logic                    ce,
    input  logic signed [CIN_W-1:0] x_in,
    input  logic signed [CIN_W-1:0] y_in,
    output logic signed [Z_W-1:0]   z_out
);

    localparam int W = CIN_W + 3;

    logic signed [W-1:0]   x_reg   [STAGES+1];
    logic signed [W-1:0]   y_reg   [STAGES+1];
    logic signed [Z_W-1:0] z_reg   [STAGES+1];
    logic                  frc_reg [STAGES+1];
    logic signed [Z_W-1:0] fz_reg  [STAGES+1];

    logic signed [W-1:0]   xe;
    logic signed [W-1:0]   ye;
    logic signed [W-1:0]   x_next;
    logic signed [W-1:0]   y_next;
    logic signed [Z_W-1:0] z_next;
    logic                  frc_next;
    logic signed [Z_W-1:0] fz_next;

    always_comb
    begin
        xe       = W'(x_in);
        ye       = W'(y_in);
        x_next   = xe;
        y_next   = ye;
        z_next   = '0;
        frc_next = 1'b0;
        fz_next  = '0;
        if (x_in == '0)
        begin
            frc_next = 1'b1;
            if (y_in == '0)
                fz_next = '0;
            else if (!y_in[CIN_W-1])
                fz_next = HALF_PI;
            else
                fz_next = -HALF_PI;
        end
        else if (x_in[CIN_W-1])
        begin
            if (!y_in[CIN_W-1])
            begin
                x_next = ye;
                y_next = -xe;
                z_next = HALF_PI;
            end
            else
            begin
                x_next = -ye;
                y_next = xe;
                z_next = -HALF_PI;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]   <= x_next;
            y_reg[0]   <= y_next;
            z_reg[0]   <= z_next;
            frc_reg[0] <= frc_next;
            fz_reg[0]  <= fz_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STAGES; i++) begin : g_iter
            localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TAB[i]);
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (!y_reg[i][W-1])
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + ANG;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - ANG;
                    end
                    frc_reg[i+1] <= frc_reg[i];
                    fz_reg[i+1]  <= fz_reg[i];
                end
            end
        end
    endgenerate

    assign z_out = frc_reg[STAGES] ? fz_reg[STAGES] : z_reg[STAGES];

endmodule

// ===== sv/quaternion_to_euler_angles.sv =====
// Throughput: one word per cycle while the output is not stalled; set by the
// 32-step square-root pipeline and the three parallel CORDIC pipelines that all
// advance together.
// A stalled output word holds the whole pipeline until it is taken.
// Reset (rst_n low, asynchronous) clears all valid bits and selects radians.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_real, quat_i, quat_j, quat_k
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // yaw_angle, pitch_angle, roll_angle
    output logic        m_tuser,   // degenerate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // output_degrees
);

    localparam int LAT     = CORDIC_STAGES + 40;
    localparam int XY_DLY  = 34;
    localparam int PY_DLY  = 33;
    localparam int SGN_DLY = CORDIC_STAGES + 34;
    localparam int DGN_DLY = LAT;

    logic ce;
    logic deg_reg;
    logic vld_reg [LAT];

    assign ce        = !m_tvalid || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deg_reg <= 1'b0;
        else if (cfg_valid)
            deg_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: products
    logic signed [Q_W-1:0] qr, qi, qj, qk;
    logic signed [P_W-1:0] p_rr_reg, p_ii_reg, p_jj_reg, p_kk_reg;
    logic signed [P_W-1:0] p_ij_reg, p_kr_reg, p_jk_reg, p_ir_reg, p_ik_reg, p_jr_reg;
    logic                  dgn_next;

    assign qr = s_tdata[15:0];
    assign qi = s_tdata[31:16];
    assign qj = s_tdata[47:32];
    assign qk = s_tdata[63:48];
    assign dgn_next = (s_tdata == '0);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_rr_reg <= qr * qr;
            p_ii_reg <= qi * qi;
            p_jj_reg <= qj * qj;
            p_kk_reg <= qk * qk;
            p_ij_reg <= qi * qj;
            p_kr_reg <= qk * qr;
            p_jk_reg <= qj * qk;
            p_ir_reg <= qi * qr;
            p_ik_reg <= qi * qk;
            p_jr_reg <= qj * qr;
        end
    end

    // stage 2: sums
    logic signed [CIN_W-1:0] e_rr, e_ii, e_jj, e_kk, e_ij, e_kr, e_jk, e_ir, e_ik, e_jr;
    logic signed [CIN_W-1:0] yaw_y_reg, yaw_x_reg, roll_y_reg, roll_x_reg, a_reg;
    logic signed [CIN_W-1:0] n_next;
    logic [32:0]             n_reg;

    assign e_rr = CIN_W'(p_rr_reg);
    assign e_ii = CIN_W'(p_ii_reg);
    assign e_jj = CIN_W'(p_jj_reg);
    assign e_kk = CIN_W'(p_kk_reg);
    assign e_ij = CIN_W'(p_ij_reg);
    assign e_kr = CIN_W'(p_kr_reg);
    assign e_jk = CIN_W'(p_jk_reg);
    assign e_ir = CIN_W'(p_ir_reg);
    assign e_ik = CIN_W'(p_ik_reg);
    assign e_jr = CIN_W'(p_jr_reg);
    assign n_next = e_ii + e_jj + e_kk + e_rr;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            yaw_y_reg  <= (e_ij + e_kr) <<< 1;
            yaw_x_reg  <= e_ii - e_jj - e_kk + e_rr;
            roll_y_reg <= (e_jk + e_ir) <<< 1;
            roll_x_reg <= e_kk + e_rr - e_ii - e_jj;
            a_reg      <= (e_jr - e_ik) <<< 1;
            n_reg      <= n_next[32:0];
        end
    end

    // stage 3: magnitude and the two factors under the root
    logic signed [CIN_W-1:0] a_neg;
    logic [32:0]             ua;
    logic [32:0]             d1_full;
    logic [33:0]             d2_full;
    logic [30:0]             d1_reg;
    logic [31:0]             d2_reg;
    logic [30:0]             py_reg;
    logic                    sgn_reg;

    assign a_neg   = -a_reg;
    assign ua      = a_reg[CIN_W-1] ? a_neg[32:0] : a_reg[32:0];
    assign d1_full = n_reg - ua;
    assign d2_full = 34'(n_reg) + 34'(ua);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d1_reg  <= d1_full[32:2];
            d2_reg  <= d2_full[33:2];
            py_reg  <= ua[32:2];
            sgn_reg <= a_reg[CIN_W-1];
        end
    end

    // stage 4: product under the root
    logic [SQ_IN_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
            prod_reg <= d1_reg * d2_reg;
    end

    logic [SQ_OUT_W-1:0] sq_root;

    qte_isqrt u_isqrt (
        .clk  (clk),
        .ce   (ce),
        .v_in (prod_reg),
        .root (sq_root)
    );

    // align operands with the root
    logic signed [CIN_W-1:0] yy_dly_reg [XY_DLY];
    logic signed [CIN_W-1:0] yx_dly_reg [XY_DLY];
    logic signed [CIN_W-1:0] ry_dly_reg [XY_DLY];
    logic signed [CIN_W-1:0] rx_dly_reg [XY_DLY];
    logic [30:0]             py_dly_reg [PY_DLY];
    logic                    sgn_dly_reg [SGN_DLY];
    logic                    dgn_dly_reg [DGN_DLY];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            yy_dly_reg[0]  <= yaw_y_reg;
            yx_dly_reg[0]  <= yaw_x_reg;
            ry_dly_reg[0]  <= roll_y_reg;
            rx_dly_reg[0]  <= roll_x_reg;
            py_dly_reg[0]  <= py_reg;
            sgn_dly_reg[0] <= sgn_reg;
            dgn_dly_reg[0] <= dgn_next;
            for (int k = 1; k < XY_DLY; k++)
            begin
                yy_dly_reg[k] <= yy_dly_reg[k-1];
                yx_dly_reg[k] <= yx_dly_reg[k-1];
                ry_dly_reg[k] <= ry_dly_reg[k-1];
                rx_dly_reg[k] <= rx_dly_reg[k-1];
            end
            for (int k = 1; k < PY_DLY; k++)
                py_dly_reg[k] <= py_dly_reg[k-1];
            for (int k = 1; k < SGN_DLY; k++)
                sgn_dly_reg[k] <= sgn_dly_reg[k-1];
            for (int k = 1; k < DGN_DLY; k++)
                dgn_dly_reg[k] <= dgn_dly_reg[k-1];
        end
    end

    logic signed [Z_W-1:0] z_yaw, z_pitch, z_roll;

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .clk   (clk),
        .ce    (ce),
        .x_in  (yx_dly_reg[XY_DLY-1]),
        .y_in  (yy_dly_reg[XY_DLY-1]),
        .z_out (z_yaw)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .clk   (clk),
        .ce    (ce),
        .x_in  (CIN_W'(sq_root)),
        .y_in  (CIN_W'(py_dly_reg[PY_DLY-1])),
        .z_out (z_pitch)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
        .clk   (clk),
        .ce    (ce),
        .x_in  (rx_dly_reg[XY_DLY-1]),
        .y_in  (ry_dly_reg[XY_DLY-1]),
        .z_out (z_roll)
    );

    // sign of pitch
    logic signed [Z_W-1:0] zs_reg [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            zs_reg[0] <= z_yaw;
            zs_reg[1] <= sgn_dly_reg[SGN_DLY-1] ? -z_pitch : z_pitch;
            zs_reg[2] <= z_roll;
        end
    end

    // degree scaling, split into two partial products
    localparam logic signed [29:0] DEG_KS = 30'(DEG_K);

    logic signed [Z_W-1:0] zm_reg [3];
    logic [44:0]           lo_reg [3];
    logic signed [47:0]    hi_reg [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < 3; k++)
            begin
                zm_reg[k] <= zs_reg[k];
                lo_reg[k] <= zs_reg[k][15:0] * DEG_K;
                hi_reg[k] <= $signed(zs_reg[k][Z_W-1:16]) * DEG_KS;
            end
        end
    end

    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        logic [15:0] r;
        if (v > 20'sd32767)
            r = 16'h7FFF;
        else if (v < -20'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic [15:0] ang [3];
    logic [47:0] out_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [63:0] dsum;
            logic signed [35:0] rsum;
            dsum = (64'(hi_reg[k]) <<< 16) + $signed(64'(lo_reg[k])) + (64'sd1 <<< 45);
            rsum = 36'(zm_reg[k]) + 36'sd65536;
            if (deg_reg)
                ang[k] = sat16(20'(dsum >>> 46));
            else
                ang[k] = sat16(20'(rsum >>> 17));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_reg <= {ang[2], ang[1], ang[0]};
    end

    assign m_tdata = out_reg;
    assign m_tuser = dgn_dly_reg[DGN_DLY-1];

endmodule

// ===== sv/qte_checker.sv =====
module qte_assert
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 48'd0)
        else $error("degenerate word carries nonzero angles");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[31:16]) <= 16'sd12900
                  && $signed(m_tdata[31:16]) >= -16'sd12900)
        else $error("pitch beyond a quarter turn");

endmodule

bind quaternion_to_euler_angles qte_assert u_qte_assert (.*);
